>>> sv/cycle_interval_jitter_monitor_core_macros.svh
// Assertion macros for the cycle interval jitter monitor.
`ifndef CYCLE_INTERVAL_JITTER_MONITOR_CORE_MACROS_SVH
`define CYCLE_INTERVAL_JITTER_MONITOR_CORE_MACROS_SVH

`ifndef SYNTH
`define CIJM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CIJM_ASSERT_PAST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ($past(rst_n) |-> (prop))) else $error(msg);
`else
`define CIJM_ASSERT(lbl, prop, msg)
`define CIJM_ASSERT_PAST(lbl, prop, msg)
`endif

`endif

>>> sv/cijm_pkg.sv
// Shared types and constants of the cycle interval jitter monitor.
`default_nettype none

package cijm_pkg;

  localparam int WINDOW_DEF = 256;
  localparam int OP_W       = 2;
  localparam int TS_W       = 64;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 63;
  localparam int CNT_W      = 48;

  localparam logic [VAL_W-1:0] MAX63 = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] MAX48 = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IVAL,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIVIDE,
    ST_UP,
    ST_DN,
    ST_PICK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> sv/cijm_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface cijm_in_if
  import cijm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [TS_W-1:0]  timestamp_ns;
  logic             send_failed;
  logic [IDX_W-1:0] history_index;

  modport source (output valid, op, timestamp_ns, send_failed, history_index,
                  input ready);
  modport sink   (input valid, op, timestamp_ns, send_failed, history_index,
                  output ready);
endinterface

interface cijm_out_if
  import cijm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] interval_ns;
  logic [CNT_W-1:0] tick_count;
  logic [CNT_W-1:0] fail_count;
  logic [VAL_W-1:0] min_interval_ns;
  logic [VAL_W-1:0] max_interval_ns;
  logic [VAL_W-1:0] mean_interval_ns;
  logic [VAL_W-1:0] jitter_ns;
  logic [VAL_W-1:0] history_value_ns;
  logic             history_valid;

  modport source (output valid, interval_ns, tick_count, fail_count, min_interval_ns,
                         max_interval_ns, mean_interval_ns, jitter_ns,
                         history_value_ns, history_valid,
                  input ready);
  modport sink   (input valid, interval_ns, tick_count, fail_count, min_interval_ns,
                        max_interval_ns, mean_interval_ns, jitter_ns,
                        history_value_ns, history_valid,
                  output ready);
endinterface

`default_nettype wire

>>> sv/cijm_div.sv
// Restoring divider, one quotient bit per cycle: interval total over tick count.
`default_nettype none

module cijm_div
  import cijm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic      [VAL_W-1:0] quotient,
  output div_stat_t             stat
);

  localparam int DCW = $clog2(VAL_W + 1);

  logic [DCW-1:0]   cnt_r;
  logic [CNT_W-1:0] rem_r;
  logic [VAL_W-1:0] quo_r;
  logic [CNT_W-1:0] dvs_r;
  logic             busy_r;
  logic             done_r;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem_r, quo_r[VAL_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCW'(VAL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VAL_W-2:0], qbit};
      rem_r <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> sv/cijm_ring.sv
// Ring memory of recent intervals, one write and one registered read port.
`default_nettype none

module cijm_ring
  import cijm_pkg::*;
#(
  parameter int DEPTH = WINDOW_DEF,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/cycle_interval_jitter_monitor_core.sv
// Top level: sequencer, statistics registers, ring memory and divider.
//
// Usage: one valid/ready input channel carries start, tick and history read
// transactions; one valid/ready output channel returns exactly one result
// transaction per input, in order. The block takes one transaction at a time.
// The bit-serial divider (interval total over tick count) runs only when the
// tick count is nonzero; the jitter subtract and compare follow it. The
// result sits in an output register, so the next input is accepted while a
// result waits; if the receiver stalls, a second finished result holds in the
// sequencer until the register drains.
// Synchronous active-low reset clears all statistics, the reference time and
// the ring write pointer; ring contents are unknown until ticks write them,
// and reads are only reported valid for entries already written.
`default_nettype none

`include "cycle_interval_jitter_monitor_core_macros.svh"

module cycle_interval_jitter_monitor_core
  import cijm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  cijm_in_if.sink      in_chan,
  cijm_out_if.source   out_chan
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  state_t state_r, state_nxt;

  op_t              op_r;
  logic [TS_W-1:0]  ts_r;
  logic             fail_r;
  logic [IDX_W-1:0] hidx_r;

  logic [TS_W-1:0]  prev_r;
  logic [VAL_W-1:0] least_r;
  logic [VAL_W-1:0] greatest_r;
  logic [VAL_W-1:0] sum_r;
  logic [CNT_W-1:0] ticks_r;
  logic [CNT_W-1:0] fails_r;
  logic [AW-1:0]    ptr_r;

  logic [VAL_W-1:0] ival_r;
  logic [VAL_W-1:0] hval_r;
  logic             hvalid_r;
  logic [VAL_W-1:0] mean_r;
  logic [VAL_W-1:0] up_r;
  logic [VAL_W-1:0] dn_r;
  logic [VAL_W-1:0] jit_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] o_ival_r, o_min_r, o_max_r, o_mean_r, o_jit_r, o_hval_r;
  logic [CNT_W-1:0] o_ticks_r, o_fails_r;
  logic             o_hvalid_r;

  logic             in_rdy, ring_re, ring_we, div_start, out_load;
  logic [TS_W:0]    tdiff;
  logic [VAL_W:0]   sum_add;
  logic             rd_ok;
  logic [VAL_W-1:0] ring_rdata;
  logic [VAL_W-1:0] quotient;
  div_stat_t        div_stat;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_chan.valid) state_nxt = ST_IVAL;
      ST_IVAL:   state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = (ticks_r == '0) ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_nxt = ST_UP;
      ST_UP:     state_nxt = ST_DN;
      ST_DN:     state_nxt = ST_PICK;
      ST_PICK:   state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_rdy    = (state_r == ST_IDLE);
    ring_re   = (state_r == ST_IVAL);
    ring_we   = (state_r == ST_ACCUM) && (op_r == OP_TICK);
    div_start = (state_r == ST_DIV_GO) && (ticks_r != '0);
    out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);
  end

  always_comb begin
    tdiff   = {1'b0, ts_r} - {1'b0, prev_r};
    sum_add = {1'b0, sum_r} + {1'b0, ival_r};
    rd_ok   = (op_r == OP_READ) && (CNT_W'(hidx_r) < ticks_r) && (32'(hidx_r) < WINDOW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_chan.valid) begin
      op_r   <= op_t'(in_chan.op);
      ts_r   <= in_chan.timestamp_ns;
      fail_r <= in_chan.send_failed;
      hidx_r <= in_chan.history_index;
    end
  end

  // Statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      least_r    <= MAX63;
      greatest_r <= '0;
      sum_r      <= '0;
      ticks_r    <= '0;
      fails_r    <= '0;
      ptr_r      <= '0;
    end else if (state_r == ST_IVAL) begin
      if (op_r == OP_START) begin
        prev_r     <= ts_r;
        least_r    <= MAX63;
        greatest_r <= '0;
        sum_r      <= '0;
        ticks_r    <= '0;
        fails_r    <= '0;
        ptr_r      <= '0;
      end else if (op_r == OP_TICK) begin
        prev_r <= ts_r;
      end
    end else if (ring_we) begin
      if (ival_r < least_r) least_r <= ival_r;
      if (ival_r > greatest_r) greatest_r <= ival_r;
      sum_r <= sum_add[VAL_W] ? MAX63 : sum_add[VAL_W-1:0];
      if (ticks_r != MAX48) begin
        ticks_r <= ticks_r + 1'b1;
        ptr_r   <= (ptr_r == AW'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      end
      if (fail_r && (fails_r != MAX48)) fails_r <= fails_r + 1'b1;
    end
  end

  // Per-transaction datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IVAL: begin
        if (op_r != OP_TICK || tdiff[TS_W]) ival_r <= '0;
        else if (tdiff[TS_W-1]) ival_r <= MAX63;
        else ival_r <= tdiff[VAL_W-1:0];
      end
      ST_ACCUM: begin
        hvalid_r <= rd_ok;
        hval_r   <= rd_ok ? ring_rdata : '0;
      end
      ST_DIV_GO: begin
        mean_r <= '0;
        jit_r  <= '0;
      end
      ST_DIVIDE: if (div_stat.done) mean_r <= quotient;
      ST_UP:     up_r <= (greatest_r >= mean_r) ? greatest_r - mean_r : '0;
      ST_DN:     dn_r <= (mean_r >= least_r) ? mean_r - least_r : '0;
      ST_PICK:   jit_r <= (up_r > dn_r) ? up_r : dn_r;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ival_r   <= ival_r;
      o_ticks_r  <= ticks_r;
      o_fails_r  <= fails_r;
      o_min_r    <= (ticks_r != '0) ? least_r : '0;
      o_max_r    <= greatest_r;
      o_mean_r   <= mean_r;
      o_jit_r    <= jit_r;
      o_hval_r   <= hval_r;
      o_hvalid_r <= hvalid_r;
    end
  end

  cijm_ring #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (ival_r),
    .re    (ring_re),
    .raddr (AW'(hidx_r)),
    .rdata (ring_rdata)
  );

  cijm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (ticks_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_chan.ready             = in_rdy;
  assign out_chan.valid            = out_valid_r;
  assign out_chan.interval_ns      = o_ival_r;
  assign out_chan.tick_count       = o_ticks_r;
  assign out_chan.fail_count       = o_fails_r;
  assign out_chan.min_interval_ns  = o_min_r;
  assign out_chan.max_interval_ns  = o_max_r;
  assign out_chan.mean_interval_ns = o_mean_r;
  assign out_chan.jitter_ns        = o_jit_r;
  assign out_chan.history_value_ns = o_hval_r;
  assign out_chan.history_valid    = o_hvalid_r;

  `CIJM_ASSERT(a_fail_le_tick, fails_r <= ticks_r, "fail count exceeds tick count")
  `CIJM_ASSERT(a_min_le_max, (ticks_r == '0) || (least_r <= greatest_r), "min above max")
  `CIJM_ASSERT(a_div_done_state, !div_stat.done || (state_r == ST_DIVIDE), "stray divide done")
  `CIJM_ASSERT_PAST(a_tick_step, (ticks_r == $past(ticks_r)) || (ticks_r == '0) || (ticks_r == $past(ticks_r) + 1'b1), "tick count jumped")

endmodule

`default_nettype wire
